[hw/rtl/periodic_lattice_neighbour_index_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic lattice neighbour index unit
// Concurrent checks are compiled in simulation and left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_LATTICE_NEIGHBOUR_INDEX_UNIT_DEFINES_SVH
`define PERIODIC_LATTICE_NEIGHBOUR_INDEX_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define PLNI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plni same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define PLNI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plni next-cycle check failed");
`else
`define PLNI_ASSERT_IMPL(lbl, ante, cons)
`define PLNI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/plni_pkg.sv]
// ----------------------------------------------------------------------------
// plni_pkg
// Shared widths, codes, types and helper functions of the neighbour unit.
// ----------------------------------------------------------------------------
package plni_pkg;

    localparam int MAX_EXTENT  = 64;
    localparam int CFG_W       = 7;
    localparam int SITE_W      = 18;
    localparam int ORDER_W     = 5;
    localparam int NUM_NBR     = 27;
    localparam int EXT_W       = $clog2(MAX_EXTENT + 1);
    localparam int COORD_W     = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
    localparam int NYZ_W       = 2 * EXT_W;
    localparam int TOTAL_W     = 3 * EXT_W;
    localparam int CMP_W       = (CFG_W > EXT_W) ? CFG_W : EXT_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [CFG_W-1:0]   SIZE_RESET = CFG_W'(8);
    localparam logic [ORDER_W-1:0] LAST_ORDER = ORDER_W'(NUM_NBR - 1);

    // Per-axis step codes.
    localparam logic [1:0] OFS_0 = 2'd0;
    localparam logic [1:0] OFS_P = 2'd1;
    localparam logic [1:0] OFS_M = 2'd2;

    typedef struct packed {
        logic [EXT_W-1:0] nx;
        logic [EXT_W-1:0] ny;
        logic [EXT_W-1:0] nz;
    } ext_t;

    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic [1:0] dz;
    } ofs_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // A register value of zero acts as one, anything above the limit as the limit.
    function automatic logic [EXT_W-1:0] eff_extent(input logic [CFG_W-1:0] raw);
        logic [CMP_W-1:0] raw_w;
        logic [EXT_W-1:0] res;
        raw_w = CMP_W'(raw);
        if (raw_w == '0)
            res = EXT_W'(1);
        else if (raw_w > CMP_W'(MAX_EXTENT))
            res = EXT_W'(MAX_EXTENT);
        else
            res = EXT_W'(raw_w);
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] wrap_step(
        input logic [COORD_W-1:0] c,
        input logic [1:0]         d,
        input logic [EXT_W-1:0]   n
    );
        logic [EXT_W:0]     c_inc;
        logic [EXT_W-1:0]   n_m1;
        logic [COORD_W-1:0] res;
        c_inc = (EXT_W + 1)'(c) + 1'b1;
        n_m1  = n - 1'b1;
        case (d)
            OFS_P:   res = (c_inc >= (EXT_W + 1)'(n)) ? '0 : COORD_W'(c_inc);
            OFS_M:   res = (c == '0) ? COORD_W'(n_m1) : c - 1'b1;
            default: res = c;
        endcase
        return res;
    endfunction

    // (a - b) mod n for coordinates already below n.
    function automatic logic [COORD_W-1:0] wrap_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [EXT_W-1:0]   n
    );
        logic [EXT_W:0] sum;
        sum = (EXT_W + 1)'(a) + (EXT_W + 1)'(n) - (EXT_W + 1)'(b);
        return (a >= b) ? (a - b) : COORD_W'(sum);
    endfunction

    // Fixed neighbour order: self, faces, edges, then corners.
    function automatic ofs_t nbr_offset(input logic [ORDER_W-1:0] k);
        ofs_t o;
        unique case (k)
            5'd0:    o = '{OFS_0, OFS_0, OFS_0};
            5'd1:    o = '{OFS_P, OFS_0, OFS_0};
            5'd2:    o = '{OFS_M, OFS_0, OFS_0};
            5'd3:    o = '{OFS_0, OFS_P, OFS_0};
            5'd4:    o = '{OFS_0, OFS_M, OFS_0};
            5'd5:    o = '{OFS_0, OFS_0, OFS_P};
            5'd6:    o = '{OFS_0, OFS_0, OFS_M};
            5'd7:    o = '{OFS_0, OFS_P, OFS_P};
            5'd8:    o = '{OFS_0, OFS_M, OFS_P};
            5'd9:    o = '{OFS_0, OFS_M, OFS_M};
            5'd10:   o = '{OFS_0, OFS_P, OFS_M};
            5'd11:   o = '{OFS_P, OFS_0, OFS_P};
            5'd12:   o = '{OFS_M, OFS_0, OFS_P};
            5'd13:   o = '{OFS_M, OFS_0, OFS_M};
            5'd14:   o = '{OFS_P, OFS_0, OFS_M};
            5'd15:   o = '{OFS_P, OFS_P, OFS_0};
            5'd16:   o = '{OFS_M, OFS_P, OFS_0};
            5'd17:   o = '{OFS_M, OFS_M, OFS_0};
            5'd18:   o = '{OFS_P, OFS_M, OFS_0};
            5'd19:   o = '{OFS_P, OFS_P, OFS_P};
            5'd20:   o = '{OFS_M, OFS_P, OFS_P};
            5'd21:   o = '{OFS_M, OFS_M, OFS_P};
            5'd22:   o = '{OFS_P, OFS_M, OFS_P};
            5'd23:   o = '{OFS_P, OFS_P, OFS_M};
            5'd24:   o = '{OFS_M, OFS_P, OFS_M};
            5'd25:   o = '{OFS_M, OFS_M, OFS_M};
            5'd26:   o = '{OFS_P, OFS_M, OFS_M};
            default: o = '{OFS_0, OFS_0, OFS_0};
        endcase
        return o;
    endfunction

endpackage

[hw/rtl/plni_front.sv]
// ----------------------------------------------------------------------------
// plni_front
// Accepts requests, clamps sites and splits them into x, y, z coordinates
// with a bit-serial divider, then queues one entry per request.
// ----------------------------------------------------------------------------
module plni_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          kind,
    input  logic [plni_pkg::SITE_W-1:0]   site_a,
    input  logic [plni_pkg::SITE_W-1:0]   site_b,
    input  plni_pkg::ext_t                ext,
    input  logic                          full,
    output logic                          busy,
    output logic                          push,
    output plni_pkg::entry_t              push_entry
);

    localparam int COORD_W = plni_pkg::COORD_W;
    localparam int SITE_W  = plni_pkg::SITE_W;
    localparam int NYZ_W   = plni_pkg::NYZ_W;
    localparam int TOTAL_W = plni_pkg::TOTAL_W;
    localparam int CLAMP_W = (SITE_W > TOTAL_W) ? SITE_W : TOTAL_W;
    localparam int DIV_W   = (SITE_W > NYZ_W + COORD_W) ? SITE_W : NYZ_W + COORD_W;
    localparam int STEP_W  = (COORD_W > 1) ? $clog2(COORD_W) : 1;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_PREP = 3'd1;
    localparam logic [2:0] F_LOAD = 3'd2;
    localparam logic [2:0] F_DIV  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]         state_reg,  state_next;
    logic               second_reg, second_next;
    logic               phase_reg,  phase_next;
    logic [STEP_W-1:0]  step_reg,   step_next;

    logic               kind_reg,   kind_next;
    logic [SITE_W-1:0]  site_a_reg, site_a_next;
    logic [SITE_W-1:0]  site_b_reg, site_b_next;
    logic [DIV_W-1:0]   rem_reg,    rem_next;
    logic [DIV_W-1:0]   dsh_reg,    dsh_next;
    logic [COORD_W-1:0] q_reg,      q_next;
    logic [COORD_W-1:0] xq_reg,     xq_next;
    logic [COORD_W-1:0] ax_reg,     ax_next;
    logic [COORD_W-1:0] ay_reg,     ay_next;
    logic [COORD_W-1:0] az_reg,     az_next;
    logic [COORD_W-1:0] bx_reg,     bx_next;
    logic [COORD_W-1:0] by_reg,     by_next;
    logic [COORD_W-1:0] bz_reg,     bz_next;
    logic [NYZ_W-1:0]   nyz_reg,    nyz_next;
    logic [TOTAL_W-1:0] total_reg,  total_next;

    logic [SITE_W-1:0]  site_sel;
    logic [CLAMP_W-1:0] site_w;
    logic [CLAMP_W-1:0] total_w;
    logic [CLAMP_W-1:0] clamped;
    logic               fits;
    logic [DIV_W-1:0]   rem_sub;
    logic [COORD_W-1:0] q_new;

    // Lattice products follow the registers continuously; the prep state
    // gives them time to settle after a configuration write.
    assign nyz_next   = NYZ_W'(ext.ny) * NYZ_W'(ext.nz);
    assign total_next = TOTAL_W'(ext.nx) * TOTAL_W'(nyz_reg);

    assign site_sel = second_reg ? site_b_reg : site_a_reg;
    assign site_w   = CLAMP_W'(site_sel);
    assign total_w  = CLAMP_W'(total_reg);
    assign clamped  = (site_w >= total_w) ? (total_w - 1'b1) : site_w;

    assign fits    = (rem_reg >= dsh_reg);
    assign rem_sub = rem_reg - dsh_reg;
    assign q_new   = (q_reg << 1) | COORD_W'(fits);

    assign busy = (state_reg != F_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        kind_next   = kind_reg;
        site_a_next = site_a_reg;
        site_b_next = site_b_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        q_next      = q_reg;
        xq_next     = xq_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        bz_next     = bz_reg;
        push        = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    site_a_next = site_a;
                    site_b_next = site_b;
                    second_next = 1'b0;
                    state_next  = F_PREP;
                end
            end
            F_PREP:
            begin
                state_next = F_LOAD;
            end
            F_LOAD:
            begin
                // Clamped site is below the lattice total, so it fits the divider.
                rem_next   = DIV_W'(clamped);
                dsh_next   = DIV_W'(nyz_reg) << (COORD_W - 1);
                q_next     = '0;
                phase_next = 1'b0;
                step_next  = STEP_W'(COORD_W - 1);
                state_next = F_DIV;
            end
            F_DIV:
            begin
                rem_next = fits ? rem_sub : rem_reg;
                dsh_next = dsh_reg >> 1;
                q_next   = q_new;
                if (step_reg == '0)
                begin
                    if (!phase_reg)
                    begin
                        // x is done; the remainder is now split by the z extent.
                        xq_next    = q_new;
                        phase_next = 1'b1;
                        step_next  = STEP_W'(COORD_W - 1);
                        dsh_next   = DIV_W'(ext.nz) << (COORD_W - 1);
                        q_next     = '0;
                    end
                    else
                    begin
                        if (!second_reg)
                        begin
                            ax_next = xq_reg;
                            ay_next = q_new;
                            az_next = COORD_W'(rem_next);
                        end
                        else
                        begin
                            bx_next = xq_reg;
                            by_next = q_new;
                            bz_next = COORD_W'(rem_next);
                        end
                        if (kind_reg && !second_reg)
                        begin
                            second_next = 1'b1;
                            state_next  = F_LOAD;
                        end
                        else
                        begin
                            state_next = F_PUSH;
                        end
                    end
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_entry.kind = kind_reg;
        if (kind_reg)
        begin
            push_entry.x = plni_pkg::wrap_diff(ax_reg, bx_reg, ext.nx);
            push_entry.y = plni_pkg::wrap_diff(ay_reg, by_reg, ext.ny);
            push_entry.z = plni_pkg::wrap_diff(az_reg, bz_reg, ext.nz);
        end
        else
        begin
            push_entry.x = ax_reg;
            push_entry.y = ay_reg;
            push_entry.z = az_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            second_reg <= 1'b0;
            phase_reg  <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        site_a_reg <= site_a_next;
        site_b_reg <= site_b_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        xq_reg     <= xq_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        bz_reg     <= bz_next;
        nyz_reg    <= nyz_next;
        total_reg  <= total_next;
    end

endmodule

[hw/rtl/plni_queue.sv]
// ----------------------------------------------------------------------------
// plni_queue
// Short first-in first-out buffer of coordinate entries between the
// splitter and the emitter.
// ----------------------------------------------------------------------------
module plni_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  plni_pkg::entry_t  push_entry,
    input  logic              pop,
    output plni_pkg::entry_t  head,
    output plni_pkg::qstat_t  status
);

    localparam int DEPTH   = plni_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    plni_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == COUNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[hw/rtl/plni_back.sv]
// ----------------------------------------------------------------------------
// plni_back
// Walks the fixed neighbour order for each queued entry and turns wrapped
// coordinates into linear site indices in a three-stage pipeline.
// ----------------------------------------------------------------------------
module plni_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  plni_pkg::ext_t                ext,
    input  plni_pkg::entry_t              head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          result_valid,
    output logic [plni_pkg::SITE_W-1:0]   result_site,
    output logic [plni_pkg::ORDER_W-1:0]  neighbour_order,
    output logic                          last
);

    localparam int COORD_W = plni_pkg::COORD_W;
    localparam int EXT_W   = plni_pkg::EXT_W;
    localparam int NYZ_W   = plni_pkg::NYZ_W;
    localparam int ORDER_W = plni_pkg::ORDER_W;
    localparam int SITE_W  = plni_pkg::SITE_W;
    localparam int PX_W    = COORD_W + NYZ_W;
    localparam int PY_W    = COORD_W + EXT_W;
    localparam int SUM_W   = PX_W + 1;

    logic [ORDER_W-1:0] k_reg, k_next;
    logic [NYZ_W-1:0]   nyz_reg;

    // Issue stage
    plni_pkg::ofs_t     ofs;
    logic [COORD_W-1:0] cx, cy, cz;
    logic [ORDER_W-1:0] ord;
    logic               lst;

    // Stage 1: wrapped coordinates
    logic               v1_reg;
    logic [COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic [ORDER_W-1:0] ord1_reg;
    logic               last1_reg;

    // Stage 2: partial products
    logic               v2_reg;
    logic [PX_W-1:0]    px_reg;
    logic [PY_W-1:0]    py_reg;
    logic [COORD_W-1:0] z2_reg;
    logic [ORDER_W-1:0] ord2_reg;
    logic               last2_reg;

    // Output stage
    logic               valid_reg;
    logic [SITE_W-1:0]  site_reg;
    logic [ORDER_W-1:0] order_reg;
    logic               last_reg;

    logic [SUM_W-1:0]   sum;

    assign ofs = plni_pkg::nbr_offset(k_reg);

    always_comb
    begin
        if (head.kind)
        begin
            cx     = head.x;
            cy     = head.y;
            cz     = head.z;
            ord    = '0;
            lst    = 1'b1;
            k_next = k_reg;
        end
        else
        begin
            cx     = plni_pkg::wrap_step(head.x, ofs.dx, ext.nx);
            cy     = plni_pkg::wrap_step(head.y, ofs.dy, ext.ny);
            cz     = plni_pkg::wrap_step(head.z, ofs.dz, ext.nz);
            ord    = k_reg;
            lst    = (k_reg == plni_pkg::LAST_ORDER);
            k_next = empty ? k_reg : (lst ? '0 : k_reg + 1'b1);
        end
    end

    assign pop = !empty && lst;

    assign sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(z2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            v1_reg    <= !empty;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nyz_reg   <= NYZ_W'(ext.ny) * NYZ_W'(ext.nz);

        x1_reg    <= cx;
        y1_reg    <= cy;
        z1_reg    <= cz;
        ord1_reg  <= ord;
        last1_reg <= lst;

        px_reg    <= PX_W'(x1_reg) * PX_W'(nyz_reg);
        py_reg    <= PY_W'(y1_reg) * PY_W'(ext.nz);
        z2_reg    <= z1_reg;
        ord2_reg  <= ord1_reg;
        last2_reg <= last1_reg;

        site_reg  <= SITE_W'(sum);
        order_reg <= ord2_reg;
        last_reg  <= last2_reg;
    end

    assign result_valid    = valid_reg;
    assign result_site     = site_reg;
    assign neighbour_order = order_reg;
    assign last            = last_reg;

endmodule

[hw/rtl/periodic_lattice_neighbour_index_unit.sv]
// ----------------------------------------------------------------------------
// periodic_lattice_neighbour_index_unit
// Neighbour and periodic-difference site index generator for a cubic lattice
// with wrap-around boundaries.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// request   start / busy         kind, site_a, site_b
// result    result_valid strobe  result_site, neighbour_order, last
// config    cfg_write            cfg_index, cfg_data
//
// The splitter divides each site serially, one quotient bit per cycle and 12
// bits per site, splitting one site for a neighbour list and two for a
// difference. A neighbour list then streams 27 results without gaps, one per
// cycle from the emitter, which takes the next queued entry once a list is done.
// Reset sets all extents to 8 and empties the queue. busy is high while the
// splitter works on a request or waits for room in the queue.
// ----------------------------------------------------------------------------
`include "periodic_lattice_neighbour_index_unit_defines.svh"

module periodic_lattice_neighbour_index_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [plni_pkg::SITE_W-1:0]     site_a,
    input  logic [plni_pkg::SITE_W-1:0]     site_b,
    input  logic                            cfg_write,
    input  logic [plni_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [plni_pkg::CFG_W-1:0]      cfg_data,
    output logic                            result_valid,
    output logic [plni_pkg::SITE_W-1:0]     result_site,
    output logic [plni_pkg::ORDER_W-1:0]    neighbour_order,
    output logic                            last
);

    logic [plni_pkg::CFG_W-1:0] size_x_reg;
    logic [plni_pkg::CFG_W-1:0] size_y_reg;
    logic [plni_pkg::CFG_W-1:0] size_z_reg;

    plni_pkg::ext_t   ext;
    plni_pkg::entry_t push_entry;
    plni_pkg::entry_t head;
    plni_pkg::qstat_t qstat;
    logic             push;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= plni_pkg::SIZE_RESET;
            size_y_reg <= plni_pkg::SIZE_RESET;
            size_z_reg <= plni_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                plni_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                plni_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                plni_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign ext.nx = plni_pkg::eff_extent(size_x_reg);
    assign ext.ny = plni_pkg::eff_extent(size_y_reg);
    assign ext.nz = plni_pkg::eff_extent(size_z_reg);

    plni_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .site_a     (site_a),
        .site_b     (site_b),
        .ext        (ext),
        .full       (qstat.full),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    plni_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (qstat)
    );

    plni_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ext             (ext),
        .head            (head),
        .empty           (qstat.empty),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_site     (result_site),
        .neighbour_order (neighbour_order),
        .last            (last)
    );

    // A request transfer always occupies the splitter on the next cycle.
    `PLNI_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    // Only self (difference) or the final neighbour may close a request.
    `PLNI_ASSERT_IMPL(a_last_order, result_valid && last, neighbour_order == '0 || neighbour_order == plni_pkg::LAST_ORDER)
    // A neighbour list streams without gaps and in order.
    `PLNI_ASSERT_NEXT(a_list_contiguous, result_valid && !last, result_valid && neighbour_order == $past(neighbour_order) + 1'b1)

endmodule

[tb/tb_periodic_lattice_neighbour_index_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for periodic_lattice_neighbour_index_unit
// Sends neighbour-list and periodic-difference requests over a range of
// lattice shapes, predicts every wrapped site index locally and checks the
// result stream in order, field by field.
// ----------------------------------------------------------------------------
module tb_periodic_lattice_neighbour_index_unit;
    import plni_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;    // no register behind it
    localparam logic KIND_LIST = 1'b0;
    localparam logic KIND_DIFF = 1'b1;
    localparam logic [1:0] S_0 = 2'd0;
    localparam logic [1:0] S_P = 2'd1;
    localparam logic [1:0] S_M = 2'd2;
    localparam int SITE_LIMIT     = 1 << SITE_W;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic              kind;
        logic [SITE_W-1:0] site_a;
        logic [SITE_W-1:0] site_b;
    } lattice_req_t;

    typedef struct packed {
        logic [SITE_W-1:0]  site;
        logic [ORDER_W-1:0] order;
        logic               last;
    } site_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 kind = 1'b0;
    logic [SITE_W-1:0]    site_a = '0;
    logic [SITE_W-1:0]    site_b = '0;
    logic                 cfg_write = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 result_valid;
    logic [SITE_W-1:0]    result_site;
    logic [ORDER_W-1:0]   neighbour_order;
    logic                 last;

    lattice_req_t pending_reqs[$];
    site_result_t expected_sites[$];

    logic [CFG_W-1:0] extent_x = SIZE_RESET;
    logic [CFG_W-1:0] extent_y = SIZE_RESET;
    logic [CFG_W-1:0] extent_z = SIZE_RESET;
    logic took_req = 1'b0;
    logic gaps_on = 1'b1;
    int   gap_left = 0;
    int   sent_reqs = 0;
    int   accepted_reqs = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    periodic_lattice_neighbour_index_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .site_a          (site_a),
        .site_b          (site_b),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .result_site     (result_site),
        .neighbour_order (neighbour_order),
        .last            (last)
    );

    always #5 clk = ~clk;

    function automatic int effective_extent(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > MAX_EXTENT)
            return MAX_EXTENT;
        return int'(raw);
    endfunction

    // Steps along x, y and z of neighbour k, two bits per axis.
    function automatic logic [5:0] neighbour_code(input int k);
        case (k)
            1:       return {S_P, S_0, S_0};
            2:       return {S_M, S_0, S_0};
            3:       return {S_0, S_P, S_0};
            4:       return {S_0, S_M, S_0};
            5:       return {S_0, S_0, S_P};
            6:       return {S_0, S_0, S_M};
            7:       return {S_0, S_P, S_P};
            8:       return {S_0, S_M, S_P};
            9:       return {S_0, S_M, S_M};
            10:      return {S_0, S_P, S_M};
            11:      return {S_P, S_0, S_P};
            12:      return {S_M, S_0, S_P};
            13:      return {S_M, S_0, S_M};
            14:      return {S_P, S_0, S_M};
            15:      return {S_P, S_P, S_0};
            16:      return {S_M, S_P, S_0};
            17:      return {S_M, S_M, S_0};
            18:      return {S_P, S_M, S_0};
            19:      return {S_P, S_P, S_P};
            20:      return {S_M, S_P, S_P};
            21:      return {S_M, S_M, S_P};
            22:      return {S_P, S_M, S_P};
            23:      return {S_P, S_P, S_M};
            24:      return {S_M, S_P, S_M};
            25:      return {S_M, S_M, S_M};
            26:      return {S_P, S_M, S_M};
            default: return {S_0, S_0, S_0};
        endcase
    endfunction

    function automatic int wrap_move(input int c, input logic [1:0] step, input int n);
        if (step == S_P)
            return (c + 1 >= n) ? 0 : c + 1;
        if (step == S_M)
            return (c == 0) ? n - 1 : c - 1;
        return c;
    endfunction

    // Sites past the end of the lattice are clamped to the last site.
    function automatic void split_site(input int s, input int nx, input int ny, input int nz,
                                       output int x, output int y, output int z);
        int sc;
        sc = (s >= nx * ny * nz) ? nx * ny * nz - 1 : s;
        z = sc % nz;
        y = (sc / nz) % ny;
        x = sc / (ny * nz);
    endfunction

    task automatic predict_sites(input lattice_req_t req);
        int nx, ny, nz;
        int ax, ay, az, bx, by, bz, dx, dy, dz;
        logic [5:0] code;
        site_result_t r;
        nx = effective_extent(extent_x);
        ny = effective_extent(extent_y);
        nz = effective_extent(extent_z);
        split_site(int'(req.site_a), nx, ny, nz, ax, ay, az);
        if (req.kind == KIND_DIFF)
        begin
            split_site(int'(req.site_b), nx, ny, nz, bx, by, bz);
            dx = (ax >= bx) ? ax - bx : ax + nx - bx;
            dy = (ay >= by) ? ay - by : ay + ny - by;
            dz = (az >= bz) ? az - bz : az + nz - bz;
            r.site  = SITE_W'(dx * ny * nz + dy * nz + dz);
            r.order = '0;
            r.last  = 1'b1;
            expected_sites.push_back(r);
        end
        else
        begin
            for (int k = 0; k < NUM_NBR; k++)
            begin
                code = neighbour_code(k);
                dx = wrap_move(ax, code[5:4], nx);
                dy = wrap_move(ay, code[3:2], ny);
                dz = wrap_move(az, code[1:0], nz);
                r.site  = SITE_W'(dx * ny * nz + dy * nz + dz);
                r.order = ORDER_W'(k);
                r.last  = (k == NUM_NBR - 1);
                expected_sites.push_back(r);
            end
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // Request driver: a new request goes out only once the previous one has
    // made its transfer, with random gap bursts in between.
    always @(negedge clk)
    begin : request_driver
        lattice_req_t req;
        if (rst_n && (!start || took_req))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(1, 13) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    req = pending_reqs.pop_front();
                    start  <= 1'b1;
                    kind   <= req.kind;
                    site_a <= req.site_a;
                    site_b <= req.site_b;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Mirrors register writes, predicts each accepted request and checks
    // every result strobe against the oldest expected site.
    always @(posedge clk)
    begin : result_monitor
        lattice_req_t seen;
        site_result_t want;
        if (!rst_n)
        begin
            extent_x <= SIZE_RESET;
            extent_y <= SIZE_RESET;
            extent_z <= SIZE_RESET;
            took_req <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SIZE_X: extent_x <= cfg_data;
                    REG_SIZE_Y: extent_y <= cfg_data;
                    REG_SIZE_Z: extent_z <= cfg_data;
                    default:    ;
                endcase
            end
            took_req <= start && !busy;
            if (start && !busy)
            begin
                seen.kind   = kind;
                seen.site_a = site_a;
                seen.site_b = site_b;
                predict_sites(seen);
                accepted_reqs++;
            end
            if (result_valid)
            begin
                if (expected_sites.size() == 0)
                    flag_mismatch($sformatf("unexpected result: site %0d order %0d last %0b",
                                            result_site, neighbour_order, last));
                else
                begin
                    want = expected_sites.pop_front();
                    if (result_site !== want.site)
                        flag_mismatch($sformatf("result_site: expected %0d, got %0d (order %0d)",
                                                want.site, result_site, want.order));
                    if (neighbour_order !== want.order)
                        flag_mismatch($sformatf("neighbour_order: expected %0d, got %0d",
                                                want.order, neighbour_order));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last: expected %0b, got %0b (order %0d)",
                                                want.last, last, want.order));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_write)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_req(input logic k, input int a, input int b);
        lattice_req_t req;
        req.kind   = k;
        req.site_a = SITE_W'(a);
        req.site_b = SITE_W'(b);
        pending_reqs.push_back(req);
        sent_reqs++;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Waits until every request has made its transfer and every site has come
    // back, then lets the pipeline settle before the registers change.
    task automatic drain_requests();
        do
            @(negedge clk);
        while (accepted_reqs != sent_reqs || expected_sites.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(127);
            2:       return CFG_W'(1);
            3:       return CFG_W'(MAX_EXTENT);
            4:       return CFG_W'($urandom_range(MAX_EXTENT + 1, 127));
            default: return CFG_W'($urandom_range(1, MAX_EXTENT));
        endcase
    endfunction

    // Coordinates on the faces of the lattice come up often, since that is
    // where the wrap logic works.
    function automatic int pick_coord(input int n);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    function automatic int pick_site();
        int nx, ny, nz, total;
        nx = effective_extent(extent_x);
        ny = effective_extent(extent_y);
        nz = effective_extent(extent_z);
        total = nx * ny * nz;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, SITE_LIMIT - 1);
            1:       return (total < SITE_LIMIT) ? $urandom_range(total, SITE_LIMIT - 1)
                                                 : total - 1;
            default: return (pick_coord(nx) * ny + pick_coord(ny)) * nz + pick_coord(nz);
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset shape, 8 by 8 by 8: corners, clamped sites, all-ones inputs.
        queue_req(KIND_LIST, 0, 0);
        queue_req(KIND_LIST, 511, 0);
        queue_req(KIND_LIST, 512, 0);
        queue_req(KIND_LIST, SITE_LIMIT - 1, SITE_LIMIT - 1);
        queue_req(KIND_LIST, 73, SITE_LIMIT - 1);
        queue_req(KIND_DIFF, 0, 0);
        queue_req(KIND_DIFF, 0, 511);
        queue_req(KIND_DIFF, 511, 0);
        queue_req(KIND_DIFF, SITE_LIMIT - 1, 5);
        queue_req(KIND_DIFF, 200, SITE_LIMIT - 1);
        drain_requests();

        // A single site: every step lands on coordinate zero.
        write_reg(REG_SIZE_X, CFG_W'(1));
        write_reg(REG_SIZE_Y, CFG_W'(1));
        write_reg(REG_SIZE_Z, CFG_W'(1));
        queue_req(KIND_LIST, 0, 0);
        queue_req(KIND_LIST, SITE_LIMIT - 1, 0);
        queue_req(KIND_DIFF, 3, 0);
        drain_requests();

        // Zero acts as one, 127 as the limit; the spare index must be ignored.
        write_reg(REG_SIZE_X, '0);
        write_reg(REG_SIZE_Y, CFG_W'(127));
        write_reg(REG_SIZE_Z, CFG_W'(MAX_EXTENT));
        write_reg(REG_SPARE, CFG_W'(5));
        queue_req(KIND_LIST, 4095, 0);
        queue_req(KIND_LIST, 64, 0);
        queue_req(KIND_DIFF, 0, 4095);
        drain_requests();

        // Largest lattice: every 18-bit site is in range.
        write_reg(REG_SIZE_X, CFG_W'(MAX_EXTENT));
        write_reg(REG_SIZE_Y, CFG_W'(MAX_EXTENT));
        queue_req(KIND_LIST, SITE_LIMIT - 1, 0);
        queue_req(KIND_LIST, 0, 0);
        queue_req(KIND_DIFF, 0, SITE_LIMIT - 1);
        queue_req(KIND_DIFF, SITE_LIMIT - 1, 0);
        queue_req(KIND_LIST, 131071, 0);
        drain_requests();

        for (int phase = 0; phase < 8; phase++)
        begin
            gaps_on = (phase < 6);
            write_reg(REG_SIZE_X, pick_extent());
            write_reg(REG_SIZE_Y, pick_extent());
            write_reg(REG_SIZE_Z, pick_extent());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE, CFG_W'($urandom_range(0, 127)));
            repeat (42) queue_req(logic'($urandom_range(0, 1)), pick_site(), pick_site());
            drain_requests();
        end

        if (mismatch_count == 0 && expected_sites.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
